// ===== rtl/core/vn3_pkg.sv =====
// ----------------------------------------------------------------------------
// vn3_pkg: shared constants for the 3-D value noise core
// Fixed-point widths and the hash constants used by the noise datapath.
// ----------------------------------------------------------------------------
package vn3_pkg;

  // Internal fraction width: all lattice values are unsigned Q0.24.
  localparam int unsigned Q = 24;

  // Default coordinate fraction width and result width.
  localparam int unsigned COORD_FRAC_BITS_DEF = 20;
  localparam int unsigned OUT_BITS_DEF = 16;

  // Coordinate width at the ports.
  localparam int unsigned COORD_W = 32;

  // Hash constants: 0.1031 and 31.32 in Q24.
  localparam logic [20:0] HASH_K = 21'd1729731;
  localparam logic [29:0] HASH_C = 30'd525462405;

  // 1.0 in Q24, one bit wider than a lattice value.
  localparam logic [Q:0] ONE_Q = 25'h100_0000;

endpackage

// ===== rtl/core/vn3_hash.sv =====
// ----------------------------------------------------------------------------
// vn3_hash: pipelined corner hash
// Maps one integer lattice corner (low 24 bits per axis) to a value in
// [0,1) in Q24, five register stages deep, one corner per cycle.
// ----------------------------------------------------------------------------
module vn3_hash (
  input  logic        clk_i,
  input  logic [23:0] cell_i_i,
  input  logic [23:0] cell_j_i,
  input  logic [23:0] cell_k_i,
  output logic [23:0] hash_o
);

  logic [44:0] mx, my, mz;
  logic [23:0] px_q, py_q, pz_q;
  logic [23:0] px2_q, py2_q, pz2_q;
  logic [53:0] m1_q, m2_q, m3_q;
  logic [55:0] msum;
  logic [31:0] d;
  logic [33:0] a_d, a_q;
  logic [32:0] b_d, b_q;
  logic [47:0] plo_q;
  logic [30:0] phi_q;
  logic [50:0] plo_d;
  logic [49:0] phi_d;
  logic [47:0] prod;
  logic [23:0] hash_q;

  assign mx = cell_i_i * vn3_pkg::HASH_K;
  assign my = cell_j_i * vn3_pkg::HASH_K;
  assign mz = cell_k_i * vn3_pkg::HASH_K;

  // Stage 1: scale each axis by K, keep the fraction.
  always_ff @(posedge clk_i) begin
    px_q <= mx[23:0];
    py_q <= my[23:0];
    pz_q <= mz[23:0];
  end

  // Stage 2: the three dot-product terms.
  always_ff @(posedge clk_i) begin
    m1_q  <= 54'(px_q) * 54'({6'd0, pz_q} + 30'(vn3_pkg::HASH_C));
    m2_q  <= 54'(py_q) * 54'({6'd0, py_q} + 30'(vn3_pkg::HASH_C));
    m3_q  <= 54'(pz_q) * 54'({6'd0, px_q} + 30'(vn3_pkg::HASH_C));
    px2_q <= px_q;
    py2_q <= py_q;
    pz2_q <= pz_q;
  end

  // Stage 3: add the offset d to every axis.
  assign msum = 56'(m1_q) + 56'(m2_q) + 56'(m3_q);
  assign d    = msum[55:24];
  assign a_d  = 34'(px2_q) + 34'(py2_q) + {1'b0, d, 1'b0};
  assign b_d  = 33'(pz2_q) + 33'(d);

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  // Stage 4: the final product in a 17-bit low half and a 16-bit high half; only bits 47:24 count.
  assign plo_d = 51'(a_q) * 51'(b_q[16:0]);
  assign phi_d = 50'(a_q) * 50'(b_q[32:17]);

  always_ff @(posedge clk_i) begin
    plo_q <= plo_d[47:0];
    phi_q <= phi_d[30:0];
  end

  // Stage 5: recombine.
  assign prod = plo_q + {phi_q, 17'd0};

  always_ff @(posedge clk_i) begin
    hash_q <= prod[47:24];
  end

  assign hash_o = hash_q;

endmodule

// ===== rtl/core/value_noise_3d_top.sv =====
// ----------------------------------------------------------------------------
// value_noise_3d_top: fully pipelined 3-D value noise
// Smoothstep-faded trilinear blend of eight hashed lattice corners.
// ----------------------------------------------------------------------------
// Usage. A request carries three signed sample coordinates with
// COORD_FRAC_BITS fraction bits. It is taken at a rising edge where start_i
// is high and busy_o is low; busy_o is always low, so a new request can be
// issued in every cycle and the block sustains one sample per clock.
// The result appears on noise_value_o with noise_valid_o high for exactly
// one cycle, and in request order. The pipeline holds one input stage, a
// five-stage corner hash, three two-stage interpolation steps and an output
// register. Smoothstep runs beside the hash and its results ride a delay
// line to meet each interpolation step.
// The receiver cannot stall the block, so the pipeline never holds; every
// stage advances each clock. Reset clears only the valid bits, so no stray
// result appears after reset; requests in flight at reset are dropped.
// The result is unsigned Q0.OUT_BITS and is clamped at its top code.
// ----------------------------------------------------------------------------
module value_noise_3d_top #(
  parameter int unsigned COORD_FRAC_BITS = vn3_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned OUT_BITS        = vn3_pkg::OUT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  output logic                noise_valid_o,
  output logic [OUT_BITS-1:0] noise_value_o
);

  localparam int unsigned Q = vn3_pkg::Q;
  localparam int unsigned LAT = 12;
  localparam logic [23:0] TOP = 24'((64'd1 << OUT_BITS) - 64'd1);

  // The block never refuses a request.
  assign busy_o = 1'b0;

  logic [LAT:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:0], start_i & ~busy_o};
    end
  end

  // Input stage: split each axis into cell, cell + 1 and a Q24 fraction.
  logic [2:0][31:0] coord;
  logic [2:0][23:0] c0_q, c1_q, f_q;

  assign coord = {coord_z_i, coord_y_i, coord_x_i};

  for (genvar ax = 0; ax < 3; ax++) begin : g_split
    logic signed [31:0] shifted;
    assign shifted = $signed(coord[ax]) >>> COORD_FRAC_BITS;
    always_ff @(posedge clk_i) begin
      c0_q[ax] <= shifted[23:0];
      c1_q[ax] <= shifted[23:0] + 24'd1;
      f_q[ax]  <= 24'(coord[ax][COORD_FRAC_BITS-1:0]) << (Q - COORD_FRAC_BITS);
    end
  end

  // Smoothstep s = f*f*(3 - 2f), two stages, then a delay line so that each
  // interpolation step finds its weight at a fixed tap.
  logic [2:0][23:0] f2_q;
  logic [2:0][25:0] t_q;
  logic [2:0][23:0] s_q [2:9];

  for (genvar ax = 0; ax < 3; ax++) begin : g_smooth
    logic [47:0] ff;
    logic [49:0] ft;
    assign ff = 48'(f_q[ax]) * 48'(f_q[ax]);
    assign ft = 50'(f2_q[ax]) * 50'(t_q[ax]);
    always_ff @(posedge clk_i) begin
      f2_q[ax] <= ff[47:24];
      t_q[ax]  <= 26'h300_0000 - {1'b0, f_q[ax], 1'b0};
      s_q[2][ax] <= ft[47:24];
    end
  end

  for (genvar k = 3; k <= 9; k++) begin : g_sdly
    always_ff @(posedge clk_i) begin
      s_q[k] <= s_q[k-1];
    end
  end

  // Eight corner hashes; corner bit 0 selects x + 1, bit 1 y + 1, bit 2 z + 1.
  logic [7:0][23:0] h;

  for (genvar c = 0; c < 8; c++) begin : g_corner
    vn3_hash u_hash (
      .clk_i    (clk_i),
      .cell_i_i (c[0] ? c1_q[0] : c0_q[0]),
      .cell_j_i (c[1] ? c1_q[1] : c0_q[1]),
      .cell_k_i (c[2] ? c1_q[2] : c0_q[2]),
      .hash_o   (h[c])
    );
  end

  // Interpolation along x: products first, then the sum in the next stage.
  logic [3:0][48:0] xa_q, xb_q;
  logic [3:0][23:0] xl_q;
  logic [24:0]      wx, wy, wz;

  assign wx = {1'b0, s_q[5][0]};
  assign wy = {1'b0, s_q[7][1]};
  assign wz = {1'b0, s_q[9][2]};

  for (genvar n = 0; n < 4; n++) begin : g_lerp_x
    logic [49:0] sum;
    assign sum = {1'b0, xa_q[n]} + {1'b0, xb_q[n]};
    always_ff @(posedge clk_i) begin
      xa_q[n] <= 49'(h[2*n]) * 49'(vn3_pkg::ONE_Q - wx);
      xb_q[n] <= 49'(h[2*n+1]) * 49'(wx);
      xl_q[n] <= sum[47:24];
    end
  end

  // Interpolation along y.
  logic [1:0][48:0] ya_q, yb_q;
  logic [1:0][23:0] yl_q;

  for (genvar n = 0; n < 2; n++) begin : g_lerp_y
    logic [49:0] sum;
    assign sum = {1'b0, ya_q[n]} + {1'b0, yb_q[n]};
    always_ff @(posedge clk_i) begin
      ya_q[n] <= 49'(xl_q[2*n]) * 49'(vn3_pkg::ONE_Q - wy);
      yb_q[n] <= 49'(xl_q[2*n+1]) * 49'(wy);
      yl_q[n] <= sum[47:24];
    end
  end

  // Interpolation along z.
  logic [48:0] za_q, zb_q;
  logic [23:0] v_q;
  logic [49:0] zsum;

  assign zsum = {1'b0, za_q} + {1'b0, zb_q};

  always_ff @(posedge clk_i) begin
    za_q <= 49'(yl_q[0]) * 49'(vn3_pkg::ONE_Q - wz);
    zb_q <= 49'(yl_q[1]) * 49'(wz);
    v_q  <= zsum[47:24];
  end

  // Output stage: scale to OUT_BITS and clamp at the top code.
  logic [23:0]         vsh;
  logic [OUT_BITS-1:0] out_d, out_q;

  assign vsh   = v_q >> (Q - OUT_BITS);
  assign out_d = (vsh > TOP) ? OUT_BITS'(TOP) : OUT_BITS'(vsh);

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign noise_valid_o = vld_q[LAT];
  assign noise_value_o = out_q;

`ifndef SYNTHESIS
  // A result strobe always traces back to a request that the block took.
  a_strobe_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |-> $past(start_i && !busy_o, LAT + 1))
    else $error("result strobe without a matching request");

  // The block never pushes back on requests.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  // The first x interpolation never rises above the larger of its two corners.
  a_lerp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> (xl_q[0] <= $past(h[0], 2) || xl_q[0] <= $past(h[1], 2)))
    else $error("x interpolation out of range");
`endif

endmodule

// ===== tb/value_noise_3d_top_tb.sv =====
// ----------------------------------------------------------------------------
// value_noise_3d_top_tb: self-checking bench for the 3-D value noise core
// Drives sample points with random gaps, predicts each noise sample from the
// hashed lattice corners and a smoothstep-faded trilinear blend, and compares
// every result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module value_noise_3d_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = vn3_pkg::COORD_FRAC_BITS_DEF;
  localparam int unsigned NOISE_W   = vn3_pkg::OUT_BITS_DEF;
  localparam int unsigned QB        = vn3_pkg::Q;
  localparam int unsigned LATENCY   = 12;
  localparam int unsigned RAND_REQS = 430;
  localparam int unsigned IDLE_LIMIT = 2000;

  // Noise predictor and pending-sample store.
  class noise_scoreboard;
    logic [NOISE_W-1:0] pending_q[$];
    int unsigned errors;

    // Lattice cell is the floor of the coordinate; the fraction is the low
    // bits widened to Q0.24.
    function void split(input logic signed [31:0] c, output longint base,
                        output longint unsigned frac);
      base = longint'(c) >>> FRAC_BITS;
      frac = longint'(c[FRAC_BITS-1:0]) << (QB - FRAC_BITS);
    endfunction

    function longint unsigned fade(input longint unsigned f);
      longint unsigned f2;
      f2 = (f * f) >> QB;
      return (f2 * (3 * (64'd1 << QB) - 2 * f)) >> QB;
    endfunction

    // Fract-based corner hash in Q24; the scaled axes and the result are taken modulo 2^24.
    function longint unsigned corner(input longint i, input longint j, input longint k);
      longint unsigned px, py, pz, d, msk;
      msk = (64'd1 << QB) - 1;
      px = (longint'(i) * longint'(vn3_pkg::HASH_K)) & msk;
      py = (longint'(j) * longint'(vn3_pkg::HASH_K)) & msk;
      pz = (longint'(k) * longint'(vn3_pkg::HASH_K)) & msk;
      d = (px * (pz + vn3_pkg::HASH_C) + py * (py + vn3_pkg::HASH_C)
           + pz * (px + vn3_pkg::HASH_C)) >> QB;
      px += d;
      py += d;
      pz += d;
      return (((px + py) * pz) >> QB) & msk;
    endfunction

    function longint unsigned mix(input longint unsigned a, b, t);
      return (a * ((64'd1 << QB) - t) + b * t) >> QB;
    endfunction

    function void note_request(input logic signed [31:0] x, y, z);
      longint cx, cy, cz;
      longint unsigned fx, fy, fz, v, top;
      split(x, cx, fx);
      split(y, cy, fy);
      split(z, cz, fz);
      fx = fade(fx);
      fy = fade(fy);
      fz = fade(fz);
      v = mix(mix(mix(corner(cx, cy, cz), corner(cx + 1, cy, cz), fx),
                  mix(corner(cx, cy + 1, cz), corner(cx + 1, cy + 1, cz), fx), fy),
              mix(mix(corner(cx, cy, cz + 1), corner(cx + 1, cy, cz + 1), fx),
                  mix(corner(cx, cy + 1, cz + 1), corner(cx + 1, cy + 1, cz + 1), fx),
                  fy), fz);
      v = v >> (QB - NOISE_W);
      top = (64'd1 << NOISE_W) - 1;
      if (v > top) v = top;
      pending_q = {pending_q, v[NOISE_W-1:0]};
    endfunction

    task check_sample(input logic [NOISE_W-1:0] got);
      logic [NOISE_W-1:0] want;
      if (pending_q.size() == 0) begin
        report("noise sample with no request pending", 0, got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) report("noise_value mismatch", want, got);
    endtask

    task report(input string what, input longint unsigned want, got);
      $display("[%0t] MISMATCH %s: expected %0d got %0d", $realtime, what, want, got);
      errors++;
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic               noise_valid_o;
  logic [NOISE_W-1:0] noise_value_o;

  noise_scoreboard sb = new();
  int unsigned idle_cycles = 0;

  value_noise_3d_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .coord_x_i, .coord_y_i, .coord_z_i,
    .noise_valid_o, .noise_value_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver cannot stall, so every strobe is checked at the edge that
  // ends its cycle. The watchdog counts edges where nothing changes hands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (noise_valid_o) sb.check_sample(noise_value_o);
      if (noise_valid_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("value_noise_3d_top regression: fail");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one; a third of requests none.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request; start stays high from edge to edge across
  // back-to-back requests and drops only when a gap follows.
  task automatic send_request(input logic signed [31:0] x, y, z, input int unsigned gap);
    start_i   <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(x, y, z);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int unsigned n;
    n = 0;
    start_i <= 1'b0;
    while (sb.pending_q.size() != 0 && n < IDLE_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // Coordinates: full-range words, plus small values near lattice lines and
  // near zero, where the cell flips sign.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
      2: return ($urandom() & ~((32'd1 << FRAC_BITS) - 1)) | $urandom_range(0, 3);
      default: return $urandom() | ((32'd1 << FRAC_BITS) - $urandom_range(1, 4));
    endcase
  endfunction

  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FMAX = (32'sd1 <<< FRAC_BITS) - 1;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: origin, extremes of every field (the cell at the top and
    // bottom of the signed range), negative coordinates, fractions at zero,
    // half and just below one.
    send_request(0, 0, 0, 0);
    send_request(CMIN, CMIN, CMIN, 0);
    send_request(CMAX, CMAX, CMAX, 1);
    send_request(CMIN, CMAX, 0, 0);
    send_request(CMAX, CMIN, -1, 0);
    send_request(-1, -1, -1, 2);
    send_request(FMAX, FMAX, FMAX, 0);
    send_request(HALF, HALF, HALF, 0);
    send_request(-HALF, HALF, -HALF, 0);
    send_request(32'sd1 <<< FRAC_BITS, -(32'sd1 <<< FRAC_BITS), 0, 3);
    send_request(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 0);
    send_request(32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0, 0);
    send_request(1, -2, FMAX + 1, 0);
    send_request(CMAX - FMAX, CMIN + FMAX, HALF, 0);

    // Hold off until the pipeline is empty before random traffic.
    drain();

    for (int unsigned n = 0; n < RAND_REQS; n++) begin
      // A burst with no gaps at all every so often.
      if ((n / 40) % 3 == 1) send_request(pick_coord(), pick_coord(), pick_coord(), 0);
      else send_request(pick_coord(), pick_coord(), pick_coord(), gap_len());
      if (n == RAND_REQS / 2) drain();
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("value_noise_3d_top regression: pass");
    end else begin
      $display("value_noise_3d_top regression: fail");
    end
    $finish;
  end

endmodule
